@@ hdl/clbp_pkg.sv @@
// ----------------------------------------------------------------------------
// clbp_pkg
// Shared types and constants of the circular LBP (P=8, R=1, riu2) block.
// ----------------------------------------------------------------------------
`default_nettype none

package clbp_pkg;

  localparam int PIX_W       = 8;
  localparam int CODE_W      = 8;
  localparam int OCOL_W      = 10;
  localparam int OROW_W      = 12;
  localparam int LW_W        = 11;
  localparam int FH_W        = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_DIM       = 3;

  localparam int LW_RESET = 1024;
  localparam int FH_RESET = 1024;

  localparam int NEIGHBORS    = 8;
  localparam int NONUNIF_CODE = NEIGHBORS + 1;
  localparam int WIN_TAPS     = 9;

  // Q0.16 bilinear weights of a diagonal sample
  localparam int Q_SHIFT  = 16;
  localparam int W_DIAG   = 32768;
  localparam int W_AXIS   = 13573;
  localparam int W_CENTER = 5622;

  localparam int FIFO_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MAP_UNIFORM  = 2'd2
  } cfg_idx_e;

  // window tap (row*3 + col), col 2 newest
  typedef logic [WIN_TAPS-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic              code_valid;
    logic [OCOL_W-1:0] out_col;
    logic [OROW_W-1:0] out_row;
    logic              frame_end;
  } meta_t;

  typedef struct packed {
    logic [CODE_W-1:0] lbp_code;
    logic              code_valid;
    logic [OCOL_W-1:0] out_col;
    logic [OROW_W-1:0] out_row;
    logic              frame_end;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/clbp_pix_if.sv @@
// ----------------------------------------------------------------------------
// clbp_pix_if
// Pixel input channel: valid/ready handshake with pixel and frame start.
// ----------------------------------------------------------------------------
`default_nettype none

interface clbp_pix_if;
  logic                       valid;
  logic                       ready;
  logic [clbp_pkg::PIX_W-1:0] pixel;
  logic                       frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

@@ hdl/clbp_code_if.sv @@
// ----------------------------------------------------------------------------
// clbp_code_if
// Code output channel: valid/ready handshake with code and position.
// ----------------------------------------------------------------------------
`default_nettype none

interface clbp_code_if;
  logic                        valid;
  logic                        ready;
  logic [clbp_pkg::CODE_W-1:0] lbp_code;
  logic                        code_valid;
  logic [clbp_pkg::OCOL_W-1:0] out_col;
  logic [clbp_pkg::OROW_W-1:0] out_row;
  logic                        frame_end;

  modport source (output valid, output lbp_code, output code_valid, output out_col,
                  output out_row, output frame_end, input ready);
  modport sink   (input valid, input lbp_code, input code_valid, input out_col,
                  input out_row, input frame_end, output ready);
endinterface

`default_nettype wire

@@ hdl/clbp_ram.sv @@
// ----------------------------------------------------------------------------
// clbp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module clbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/clbp_line.sv @@
// ----------------------------------------------------------------------------
// clbp_line
// Raster counters, two line-store RAMs with read-modify-write and
// forwarding, and the 3x3 pixel window.
// ----------------------------------------------------------------------------
`default_nettype none

module clbp_line #(
  parameter int MAX_WIDTH = clbp_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [clbp_pkg::PIX_W-1:0]    pixel_i,
  input  logic                          frame_start_i,
  input  logic [clbp_pkg::LW_W-1:0]     line_width_i,
  input  logic [clbp_pkg::FH_W-1:0]     frame_height_i,
  output logic                          win_valid_o,
  output clbp_pkg::win_t                win_o,
  output clbp_pkg::meta_t               meta_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = CW + 1;
  localparam int HW = clbp_pkg::FH_W;
  localparam int RW = clbp_pkg::OROW_W;
  localparam int PW = clbp_pkg::PIX_W;

  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [EW-1:0] c, nc;
  logic [HW-1:0] r, r1;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [CW-1:0] col_m2;
  logic [RW-1:0] row_m2;
  clbp_pkg::meta_t meta_cur;

  logic            s1_valid_q;
  logic [PW-1:0]   s1_pix_q;
  logic [CW-1:0]   s1_col_q;
  clbp_pkg::meta_t s1_meta_q;

  logic            fwd_q;
  logic [PW-1:0]   fwd_top_q;
  logic [PW-1:0]   fwd_mid_q;
  logic [PW-1:0]   up_rd, lo_rd;
  logic [PW-1:0]   top_sel, mid_sel;

  clbp_pkg::win_t  window_q, window_d;
  logic            s2_valid_q;
  clbp_pkg::meta_t s2_meta_q;

  // size seen by the counters, saturated into the legal range
  always_comb begin
    if (line_width_i < clbp_pkg::LW_W'(clbp_pkg::MIN_DIM)) begin
      eff_w = EW'(clbp_pkg::MIN_DIM);
    end else if (32'(line_width_i) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(line_width_i);
    end
    if (frame_height_i < HW'(clbp_pkg::MIN_DIM)) begin
      eff_h = HW'(clbp_pkg::MIN_DIM);
    end else if (frame_height_i > HW'(clbp_pkg::MAX_HEIGHT)) begin
      eff_h = HW'(clbp_pkg::MAX_HEIGHT);
    end else begin
      eff_h = frame_height_i;
    end
  end

  always_comb begin
    c = frame_start_i ? '0 : EW'(col_q);
    r = frame_start_i ? '0 : HW'(row_q);
    if (c >= eff_w) begin
      c = '0;
      r = (r + 1'b1 >= eff_h) ? '0 : r + 1'b1;
    end
    if (r >= eff_h) begin
      r = '0;
    end
    col_cur = c[CW-1:0];
    row_cur = r[RW-1:0];
    nc      = c + 1'b1;
    r1      = (r + 1'b1 >= eff_h) ? '0 : r + 1'b1;
    if (nc >= eff_w) begin
      col_d = '0;
      row_d = r1[RW-1:0];
    end else begin
      col_d = nc[CW-1:0];
      row_d = row_cur;
    end
  end

  always_comb begin
    col_m2              = col_cur - CW'(2);
    row_m2              = row_cur - RW'(2);
    meta_cur.code_valid = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
    meta_cur.out_col    = meta_cur.code_valid ? clbp_pkg::OCOL_W'(col_m2) : '0;
    meta_cur.out_row    = meta_cur.code_valid ? row_m2 : '0;
    meta_cur.frame_end  = meta_cur.code_valid && (r == eff_h - 1'b1) && (c == eff_w - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      s1_valid_q <= accept_i;
      s2_valid_q <= s1_valid_q;
      // write-back of the item ahead hits the entry being read now
      fwd_q      <= accept_i && s1_valid_q && (s1_col_q == col_cur);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_pix_q  <= pixel_i;
      s1_col_q  <= col_cur;
      s1_meta_q <= meta_cur;
      fwd_top_q <= mid_sel;
      fwd_mid_q <= s1_pix_q;
    end
    if (s1_valid_q) begin
      window_q  <= window_d;
      s2_meta_q <= s1_meta_q;
    end
  end

  clbp_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (mid_sel),
    .re_i    (accept_i),
    .raddr_i (col_cur),
    .rdata_o (up_rd)
  );

  clbp_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_ram_lower (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (accept_i),
    .raddr_i (col_cur),
    .rdata_o (lo_rd)
  );

  assign top_sel = fwd_q ? fwd_top_q : up_rd;
  assign mid_sel = fwd_q ? fwd_mid_q : lo_rd;

  always_comb begin
    window_d = window_q;
    for (int i = 0; i < 3; i++) begin
      window_d[i*3]     = window_q[i*3 + 1];
      window_d[i*3 + 1] = window_q[i*3 + 2];
    end
    window_d[2] = top_sel;
    window_d[5] = mid_sel;
    window_d[8] = s1_pix_q;
  end

  assign win_valid_o = s2_valid_q;
  assign win_o       = window_q;
  assign meta_o      = s2_meta_q;

endmodule

`default_nettype wire

@@ hdl/clbp_code.sv @@
// ----------------------------------------------------------------------------
// clbp_code
// Eight circular samples against the center, registered raw code, then
// the optional riu2 mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module clbp_code (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  clbp_pkg::win_t  win_i,
  input  clbp_pkg::meta_t meta_i,
  input  logic            map_uniform_i,
  output logic            valid_o,
  output clbp_pkg::res_t  res_o
);

  localparam int PW    = clbp_pkg::PIX_W;
  localparam int SUM_W = PW + clbp_pkg::Q_SHIFT + 1;
  localparam int CDW   = clbp_pkg::CODE_W;

  function automatic logic diag_ge(input logic [PW-1:0] d, input logic [PW-1:0] a1,
                                   input logic [PW-1:0] a2, input logic [PW-1:0] ctr);
    logic [SUM_W-1:0] t;
    logic [SUM_W-1:0] lim;
    t   = SUM_W'(d) * SUM_W'(clbp_pkg::W_DIAG)
        + SUM_W'(a1) * SUM_W'(clbp_pkg::W_AXIS)
        + SUM_W'(a2) * SUM_W'(clbp_pkg::W_AXIS)
        + SUM_W'(ctr) * SUM_W'(clbp_pkg::W_CENTER);
    lim = SUM_W'(ctr) << clbp_pkg::Q_SHIFT;
    return t >= lim;
  endfunction

  function automatic logic [3:0] popcnt8(input logic [CDW-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < CDW; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  logic [PW-1:0]   ctr, below, left, above, right;
  logic [CDW-1:0]  raw_d, raw_q, rot, mapped;
  clbp_pkg::meta_t meta_q;
  logic            valid_q;

  always_comb begin
    ctr   = win_i[4];
    below = win_i[7];
    left  = win_i[3];
    above = win_i[1];
    right = win_i[5];
    raw_d[0] = below >= ctr;
    raw_d[1] = diag_ge(win_i[6], left, below, ctr);
    raw_d[2] = left >= ctr;
    raw_d[3] = diag_ge(win_i[0], left, above, ctr);
    raw_d[4] = above >= ctr;
    raw_d[5] = diag_ge(win_i[2], above, right, ctr);
    raw_d[6] = right >= ctr;
    raw_d[7] = diag_ge(win_i[8], below, right, ctr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      raw_q  <= raw_d;
      meta_q <= meta_i;
    end
  end

  always_comb begin
    rot = {raw_q[0], raw_q[CDW-1:1]};
    if (popcnt8(raw_q ^ rot) <= 4'd2) begin
      mapped = CDW'(popcnt8(raw_q));
    end else begin
      mapped = CDW'(clbp_pkg::NONUNIF_CODE);
    end
  end

  always_comb begin
    res_o.code_valid = meta_q.code_valid;
    res_o.out_col    = meta_q.out_col;
    res_o.out_row    = meta_q.out_row;
    res_o.frame_end  = meta_q.frame_end;
    if (!meta_q.code_valid) begin
      res_o.lbp_code = '0;
    end else if (map_uniform_i) begin
      res_o.lbp_code = mapped;
    end else begin
      res_o.lbp_code = raw_q;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

@@ hdl/clbp_fifo.sv @@
// ----------------------------------------------------------------------------
// clbp_fifo
// Small result queue that decouples the pipeline from output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module clbp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clbp_pkg::res_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output clbp_pkg::res_t data_o
);

  localparam int AW  = $clog2(clbp_pkg::FIFO_DEPTH);
  localparam int CNW = $clog2(clbp_pkg::FIFO_DEPTH + 1);

  clbp_pkg::res_t mem_q [clbp_pkg::FIFO_DEPTH];
  logic [AW-1:0]  wptr_q, rptr_q;
  logic [CNW-1:0] count_q;
  logic           pop;

  assign valid_o = count_q != '0;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      unique case ({push_i, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/circular_lbp_riu2_code.sv @@
// ----------------------------------------------------------------------------
// circular_lbp_riu2_code
// Streaming circular LBP (8 neighbors, radius 1) with optional riu2 code.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  pix_i     in   valid/ready          pixel, frame_start
//  code_o    out  valid/ready          lbp_code, code_valid, out_col, out_row,
//                                      frame_end
//  cfg       in   cfg_we_i, no stall   cfg_idx_i, cfg_data_i
//
//  One pixel per clock sustained while code_o keeps up; one result per pixel,
//  passing line-store read, window shift, sample compare and queue in turn.
//  Each line-store RAM does one read and one write per pixel; a write-back
//  to the entry read in the same cycle is forwarded.
//  Reset clears counters and queue; line stores need no clearing.
//  Input stalls only when eight items are in flight or queued.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_lbp_riu2_code #(
  parameter int MAX_WIDTH = clbp_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [clbp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [clbp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  clbp_pix_if.sink                            pix_i,
  clbp_code_if.source                         code_o
);

  localparam int CNW = $clog2(clbp_pkg::FIFO_DEPTH + 1);

  logic [clbp_pkg::LW_W-1:0] line_width_q;
  logic [clbp_pkg::FH_W-1:0] frame_height_q;
  logic                      map_uniform_q;

  logic            accept;
  logic            pop;
  logic [CNW-1:0]  inflight_q;
  logic            win_valid;
  clbp_pkg::win_t  win;
  clbp_pkg::meta_t win_meta;
  logic            res_valid;
  clbp_pkg::res_t  res;
  clbp_pkg::res_t  head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= clbp_pkg::LW_W'(clbp_pkg::LW_RESET);
      frame_height_q <= clbp_pkg::FH_W'(clbp_pkg::FH_RESET);
      map_uniform_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        clbp_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data_i[clbp_pkg::LW_W-1:0];
        clbp_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[clbp_pkg::FH_W-1:0];
        clbp_pkg::REG_MAP_UNIFORM:  map_uniform_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // items accepted and not yet taken; bounds the queue
  assign pix_i.ready = inflight_q < CNW'(clbp_pkg::FIFO_DEPTH);
  assign accept      = pix_i.valid && pix_i.ready;
  assign pop         = code_o.valid && code_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      unique case ({accept, pop})
        2'b10:   inflight_q <= inflight_q + 1'b1;
        2'b01:   inflight_q <= inflight_q - 1'b1;
        default: inflight_q <= inflight_q;
      endcase
    end
  end

  clbp_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .pixel_i        (pix_i.pixel),
    .frame_start_i  (pix_i.frame_start),
    .line_width_i   (line_width_q),
    .frame_height_i (frame_height_q),
    .win_valid_o    (win_valid),
    .win_o          (win),
    .meta_o         (win_meta)
  );

  clbp_code u_code (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (win_valid),
    .win_i         (win),
    .meta_i        (win_meta),
    .map_uniform_i (map_uniform_q),
    .valid_o       (res_valid),
    .res_o         (res)
  );

  clbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .valid_o (code_o.valid),
    .ready_i (code_o.ready),
    .data_o  (head)
  );

  assign code_o.lbp_code   = head.lbp_code;
  assign code_o.code_valid = head.code_valid;
  assign code_o.out_col    = head.out_col;
  assign code_o.out_row    = head.out_row;
  assign code_o.frame_end  = head.frame_end;

endmodule

`default_nettype wire

@@ hdl/clbp_checker.sv @@
// ----------------------------------------------------------------------------
// clbp_checker
// Port-level checks of the circular LBP block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clbp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [clbp_pkg::CODE_W-1:0] lbp_code_i,
  input logic                        code_valid_i,
  input logic [clbp_pkg::OCOL_W-1:0] out_col_i,
  input logic [clbp_pkg::OROW_W-1:0] out_row_i,
  input logic                        frame_end_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(lbp_code_i)
      && $stable(out_col_i) && $stable(out_row_i))
    else $error("stalled item changed");

  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !code_valid_i |-> lbp_code_i == '0 && out_col_i == '0
      && out_row_i == '0 && !frame_end_i)
    else $error("border item carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 4))
    else $error("item appeared without matching input");

endmodule

bind circular_lbp_riu2_code clbp_checker u_clbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (pix_i.valid),
  .in_ready_i   (pix_i.ready),
  .out_valid_i  (code_o.valid),
  .out_ready_i  (code_o.ready),
  .lbp_code_i   (code_o.lbp_code),
  .code_valid_i (code_o.code_valid),
  .out_col_i    (code_o.out_col),
  .out_row_i    (code_o.out_row),
  .frame_end_i  (code_o.frame_end)
);

`default_nettype wire
